[src/scale_weight_frame_sequencer_defines.svh]
// Assertion macros shared by the scale weight frame sequencer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SCALE_WEIGHT_FRAME_SEQUENCER_DEFINES_SVH
`define SCALE_WEIGHT_FRAME_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SWFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swfs assertion failed");

// next-cycle implication, checked out of reset
`define SWFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swfs assertion failed");

`endif

[src/swfs_pkg.sv]
// Types and constants for the scale weight frame sequencer.
// No dependencies; imported by scale_weight_frame_sequencer and the testbench files.
package swfs_pkg;

    localparam int WEIGHT_W  = 20;
    localparam int STEP_W    = 8;
    localparam int CNT_W     = 8;
    localparam int SCNT_W    = 9;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int DEC_W     = 27;   // holds 9 * 10^7 and 10^8
    localparam int DEC_POS_W = 3;    // decimal positions 0..7
    localparam int WEIGHT_DEC_DIGITS = 7;  // 2^20 - 1 has 7 decimal digits

    typedef logic [7:0]          t_byte;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef logic [DEC_W-1:0]    t_dec;

    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_LIMIT = 2'd2;

    localparam t_byte CH_AT   = 8'h40;
    localparam t_byte CH_D    = 8'h44;
    localparam t_byte CH_F    = 8'h46;
    localparam t_byte CH_ZERO = 8'h30;
    localparam t_byte CH_CR   = 8'h0D;

    localparam t_weight        FINAL_WEIGHT_RST = 20'd2260;
    localparam logic [CNT_W-1:0] ZERO_COUNT_RST  = 8'd10;
    localparam logic [CNT_W-1:0] STABLE_LIMIT_RST = 8'd10;
    localparam logic [SCNT_W-1:0] SCNT_MAX       = 9'h1FF;

    function automatic t_dec pow10(input logic [DEC_POS_W-1:0] pos);
        t_dec p;
        case (pos)
            3'd0:    p = 27'd1;
            3'd1:    p = 27'd10;
            3'd2:    p = 27'd100;
            3'd3:    p = 27'd1000;
            3'd4:    p = 27'd10000;
            3'd5:    p = 27'd100000;
            3'd6:    p = 27'd1000000;
            default: p = 27'd10000000;
        endcase
        return p;
    endfunction

endpackage

[src/scale_weight_frame_sequencer.sv]
// Scale weight frame sequencer: phase/weight update and ASCII frame serializer.
// Depends on swfs_pkg and scale_weight_frame_sequencer_defines.svh.
//
// Usage:
//   Input channel (i_valid / o_stall) takes one tick word with a rise and a
//   fall step. Each tick updates the phase and weight in the accept cycle and
//   either queues one frame or stays silent. Output channel (o_valid /
//   i_stall) moves one frame byte per word: prefix, DIGITS decimal digits,
//   CR with o_last_byte set.
//   Config writes (i_cfg_we, i_cfg_idx, i_cfg_data) are registered; the
//   user must make them only while idle, which the block does not enforce;
//   index 3 is ignored. The first byte of a frame passes through the
//   holding register, the serializer and the output register after its tick.
//   When DIGITS < 7, upper decimal digits of the 20-bit weight are stripped
//   one per cycle by the digit unit without a byte, the first alongside the
//   prefix. The digit unit handles one decimal position per cycle while the
//   output is not stalled. One frame can wait in a holding register while
//   another is sent, so a tick is accepted while the previous frame is still
//   going out. Reset: phase zero, weight 0, counters 0, registers to their
//   defaults, no word pending. A stalled receiver freezes the serializer;
//   o_stall is high while the holding register is full and cannot load.
`include "scale_weight_frame_sequencer_defines.svh"

module scale_weight_frame_sequencer
    import swfs_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [STEP_W-1:0]    i_rise_step,
    input  logic [STEP_W-1:0]    i_fall_step,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [7:0]           o_frame_byte,
    output logic                 o_last_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int TOP_DIG = (DIGITS > WEIGHT_DEC_DIGITS) ? DIGITS : WEIGHT_DEC_DIGITS;
    localparam logic [DEC_POS_W-1:0] TOP_POS = DEC_POS_W'(TOP_DIG - 1);
    localparam logic [DEC_POS_W:0]   DIG_LIM = (DEC_POS_W + 1)'(DIGITS);

    localparam logic [2:0] PH_ZERO    = 3'd0;
    localparam logic [2:0] PH_RISE    = 3'd1;
    localparam logic [2:0] PH_STABLE  = 3'd2;
    localparam logic [2:0] PH_DESCEND = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    // config
    t_weight           r_final;
    logic [CNT_W-1:0]  r_zcnt;
    logic [CNT_W-1:0]  r_slim;

    // sequencer state
    logic [2:0]        r_phase, n_phase;
    t_weight           r_weight, n_weight;
    logic [CNT_W-1:0]  r_zsent, n_zsent;
    logic [SCNT_W-1:0] r_ssent, n_ssent;

    // holding register for one frame
    logic              r_pend_valid;
    t_byte             r_pend_prefix, n_pend_prefix;
    t_weight           r_pend_value, n_pend_value;
    logic              n_frame;

    // serializer
    logic                 r_busy, r_pre, r_tail;
    logic [DEC_POS_W-1:0] r_dpos;
    t_weight              r_rem, n_rem;
    t_byte                r_prefix;
    logic                 r_out_valid, r_out_last;
    t_byte                r_out_byte;

    logic          accept, load, out_free, adv, strip, emit, consume, done;
    logic [3:0]    dig;
    t_dec          p, thr, sub;
    logic [WEIGHT_W:0] sum;
    logic [SCNT_W-1:0] ssent_inc;
    t_byte         emit_byte;

    // digit unit: one decimal position of r_rem per cycle while the serializer advances
    always_comb begin
        p   = pow10(r_dpos);
        dig = 4'd0;
        sub = '0;
        for (int m = 1; m <= 9; m++) begin
            thr = p * DEC_W'(m);
            if (DEC_W'(r_rem) >= thr) begin
                dig = 4'(m);
                sub = thr;
            end
        end
        n_rem = WEIGHT_W'(DEC_W'(r_rem) - sub);
    end

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = r_busy && out_free;
    assign strip    = {1'b0, r_dpos} >= DIG_LIM;
    assign emit     = r_pre || r_tail || !strip;
    assign consume  = !r_tail && (!r_pre || strip);
    assign done     = !r_pre && r_tail;
    assign load     = r_pend_valid && (!r_busy || (adv && done));
    assign o_stall  = r_pend_valid && !load;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        if (r_pre) begin
            emit_byte = r_prefix;
        end else if (r_tail) begin
            emit_byte = CH_CR;
        end else begin
            emit_byte = CH_ZERO + {4'b0, dig};
        end
    end

    // tick update
    always_comb begin
        n_phase       = r_phase;
        n_weight      = r_weight;
        n_zsent       = r_zsent;
        n_ssent       = r_ssent;
        n_frame       = 1'b0;
        n_pend_prefix = CH_AT;
        n_pend_value  = '0;
        sum           = {1'b0, r_weight} + (WEIGHT_W + 1)'(i_rise_step);
        ssent_inc     = (r_ssent < SCNT_MAX) ? r_ssent + 1'b1 : r_ssent;
        unique case (r_phase)
            PH_ZERO: begin
                if (r_zsent < r_zcnt) begin
                    n_zsent = r_zsent + 1'b1;
                    n_frame = 1'b1;
                end else begin
                    n_phase = PH_RISE;
                end
            end
            PH_RISE: begin
                n_frame = 1'b1;
                if (sum >= {1'b0, r_final}) begin
                    n_weight = r_final;
                    n_phase  = PH_STABLE;
                end else begin
                    n_weight = sum[WEIGHT_W-1:0];
                end
                n_pend_value = n_weight;
            end
            PH_STABLE: begin
                n_frame       = 1'b1;
                n_ssent       = ssent_inc;
                n_pend_prefix = CH_D;
                n_pend_value  = r_weight;
                if (ssent_inc > {1'b0, r_slim}) begin
                    n_phase = PH_DESCEND;
                end
            end
            PH_DESCEND: begin
                if (r_weight != '0) begin
                    n_frame      = 1'b1;
                    n_weight     = (r_weight > WEIGHT_W'(i_fall_step)) ?
                                   r_weight - WEIGHT_W'(i_fall_step) : '0;
                    n_pend_value = n_weight;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_frame       = 1'b1;
                n_pend_prefix = CH_F;
            end
        endcase
    end

    // config and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final  <= FINAL_WEIGHT_RST;
            r_zcnt   <= ZERO_COUNT_RST;
            r_slim   <= STABLE_LIMIT_RST;
            r_phase  <= PH_ZERO;
            r_weight <= '0;
            r_zsent  <= '0;
            r_ssent  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FINAL_WEIGHT: r_final <= i_cfg_data;
                    CFG_ZERO_COUNT:   r_zcnt  <= i_cfg_data[CNT_W-1:0];
                    CFG_STABLE_LIMIT: r_slim  <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_weight <= n_weight;
                r_zsent  <= n_zsent;
                r_ssent  <= n_ssent;
            end
        end
    end

    // control of holding register, serializer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_busy       <= 1'b0;
            r_pre        <= 1'b0;
            r_tail       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_pend_valid <= n_frame;
            end else if (load) begin
                r_pend_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= adv && emit;
            end
            if (load) begin
                r_busy <= 1'b1;
                r_pre  <= 1'b1;
                r_tail <= 1'b0;
            end else if (adv) begin
                r_pre <= 1'b0;
                if (consume && r_dpos == '0) begin
                    r_tail <= 1'b1;
                end
                if (done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept && n_frame) begin
            r_pend_prefix <= n_pend_prefix;
            r_pend_value  <= n_pend_value;
        end
        if (load) begin
            r_prefix <= r_pend_prefix;
            r_rem    <= r_pend_value;
            r_dpos   <= TOP_POS;
        end else if (adv && consume) begin
            r_rem <= n_rem;
            if (r_dpos != '0) begin
                r_dpos <= r_dpos - 1'b1;
            end
        end
        if (adv && emit) begin
            r_out_byte <= emit_byte;
            r_out_last <= done;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_last_byte  = r_out_last;

    `SWFS_ASSERT_NEXT(a_prefix_after_cr, i_clk, i_rst_n,
        o_valid && !i_stall && o_last_byte,
        !o_valid || o_frame_byte == CH_AT || o_frame_byte == CH_D || o_frame_byte == CH_F)
    `SWFS_ASSERT_IMPL(a_rem_in_range, i_clk, i_rst_n,
        r_busy && !r_tail,
        DEC_W'(r_rem) < (pow10(r_dpos) * DEC_W'(10)))
    `SWFS_ASSERT_NEXT(a_done_sticks, i_clk, i_rst_n,
        r_phase == PH_DONE,
        r_phase == PH_DONE)
    `SWFS_ASSERT_IMPL(a_last_only_cr, i_clk, i_rst_n,
        o_valid && o_last_byte,
        o_frame_byte == CH_CR)

endmodule

[tb/scale_weight_frame_sequencer_chk.sv]
// Checker for the scale weight frame sequencer: follows ticks and register writes,
// predicts every frame word and compares it with what leaves the block.
// Depends on swfs_pkg.
`timescale 1ns / 100ps

module scale_weight_frame_sequencer_chk
    import swfs_pkg::*;
#(
    parameter int DIGITS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tick_valid,
    input  logic                 i_tick_stall,
    input  logic [STEP_W-1:0]    i_rise_step,
    input  logic [STEP_W-1:0]    i_fall_step,
    input  logic                 i_byte_valid,
    input  logic                 i_byte_stall,
    input  logic [7:0]           i_frame_byte,
    input  logic                 i_last_byte,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_frames
);

    typedef enum logic [2:0] {
        SEQ_ZERO,
        SEQ_RISE,
        SEQ_STABLE,
        SEQ_DESCEND,
        SEQ_DONE
    } t_seq_phase;

    typedef struct packed {
        t_byte chr;
        logic  last;
    } t_due_byte;

    t_weight           final_wt;
    logic [CNT_W-1:0]  zero_target;
    logic [CNT_W-1:0]  stable_lim;

    t_seq_phase        seq_phase;
    t_weight           cur_wt;
    logic [CNT_W-1:0]  zero_sent;
    logic [SCNT_W-1:0] stable_sent;

    t_due_byte         frame_bytes_due[$];

    task automatic queue_frame(input t_byte prefix, input t_weight value);
        int    rest;
        t_byte digs[DIGITS];
        rest = int'(value) % (10 ** DIGITS);
        for (int k = DIGITS - 1; k >= 0; k--) begin
            digs[k] = CH_ZERO + t_byte'(rest % 10);
            rest = rest / 10;
        end
        frame_bytes_due.push_back('{chr: prefix, last: 1'b0});
        for (int k = 0; k < DIGITS; k++) begin
            frame_bytes_due.push_back('{chr: digs[k], last: 1'b0});
        end
        frame_bytes_due.push_back('{chr: CH_CR, last: 1'b1});
    endtask

    task automatic advance_tick(input logic [STEP_W-1:0] rise, input logic [STEP_W-1:0] fall);
        int sum;
        case (seq_phase)
            SEQ_ZERO: begin
                if (zero_sent < zero_target) begin
                    zero_sent = zero_sent + 1'b1;
                    queue_frame(CH_AT, '0);
                end else begin
                    seq_phase = SEQ_RISE;
                end
            end
            SEQ_RISE: begin
                sum = int'(cur_wt) + int'(rise);
                if (sum >= int'(final_wt)) begin
                    cur_wt    = final_wt;
                    seq_phase = SEQ_STABLE;
                end else begin
                    cur_wt = t_weight'(sum);
                end
                queue_frame(CH_AT, cur_wt);
            end
            SEQ_STABLE: begin
                if (stable_sent != SCNT_MAX) stable_sent = stable_sent + 1'b1;
                if (stable_sent > stable_lim) seq_phase = SEQ_DESCEND;
                queue_frame(CH_D, cur_wt);
            end
            SEQ_DESCEND: begin
                if (cur_wt != '0) begin
                    cur_wt = (cur_wt > fall) ? cur_wt - fall : '0;
                    queue_frame(CH_AT, cur_wt);
                end else begin
                    seq_phase = SEQ_DONE;
                end
            end
            default: queue_frame(CH_F, '0);
        endcase
    endtask

    always @(posedge i_clk) begin : monitor
        t_due_byte due;
        if (!i_rst_n) begin
            final_wt    = FINAL_WEIGHT_RST;
            zero_target = ZERO_COUNT_RST;
            stable_lim  = STABLE_LIMIT_RST;
            seq_phase   = SEQ_ZERO;
            cur_wt      = '0;
            zero_sent   = '0;
            stable_sent = '0;
            frame_bytes_due.delete();
            o_errors    = 0;
            o_frames    = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FINAL_WEIGHT: final_wt    = i_cfg_data[WEIGHT_W-1:0];
                    CFG_ZERO_COUNT:   zero_target = i_cfg_data[CNT_W-1:0];
                    CFG_STABLE_LIMIT: stable_lim  = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_tick_valid && !i_tick_stall) begin
                advance_tick(i_rise_step, i_fall_step);
            end
            if (i_byte_valid && !i_byte_stall) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("unexpected word: frame_byte 0x%02h last_byte %0b",
                           i_frame_byte, i_last_byte);
                    o_errors++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (i_frame_byte !== due.chr) begin
                        $error("frame_byte: expected 0x%02h, got 0x%02h", due.chr, i_frame_byte);
                        o_errors++;
                    end
                    if (i_last_byte !== due.last) begin
                        $error("last_byte: expected %0b, got %0b", due.last, i_last_byte);
                        o_errors++;
                    end
                    if (due.last) o_frames++;
                end
            end
        end
        o_pending = frame_bytes_due.size();
    end

endmodule

[tb/scale_weight_frame_sequencer_tb.sv]
// Top of the scale weight frame sequencer testbench: clock, reset, tick and
// register stimulus, receiver stalls, watchdog and verdict.
// Depends on swfs_pkg, scale_weight_frame_sequencer and scale_weight_frame_sequencer_chk.
`timescale 1ns / 100ps

module scale_weight_frame_sequencer_tb;
    import swfs_pkg::*;

    localparam int DIGITS         = 6;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int CLIMB_TARGET   = 8000;
    localparam int STABLE_TICKS   = 30;
    localparam int TAIL_TICKS     = 130;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BLINK} t_rx_mode;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 tick_valid = 1'b0;
    logic                 tick_stall;
    logic [STEP_W-1:0]    rise_step = '0;
    logic [STEP_W-1:0]    fall_step = '0;
    logic                 byte_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           frame_byte;
    logic                 last_byte;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    int       chk_errors;
    int       chk_pending;
    int       chk_frames;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       ticks_sent = 0;
    int       stall_left = 0;
    t_rx_mode stall_mode = RX_FREE;

    always #1 clk = ~clk;

    scale_weight_frame_sequencer #(
        .DIGITS(DIGITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (tick_valid),
        .o_stall     (tick_stall),
        .i_rise_step (rise_step),
        .i_fall_step (fall_step),
        .o_valid     (byte_valid),
        .i_stall     (out_stall),
        .o_frame_byte(frame_byte),
        .o_last_byte (last_byte),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    scale_weight_frame_sequencer_chk #(
        .DIGITS(DIGITS)
    ) frame_chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_tick_valid(tick_valid),
        .i_tick_stall(tick_stall),
        .i_rise_step (rise_step),
        .i_fall_step (fall_step),
        .i_byte_valid(byte_valid),
        .i_byte_stall(out_stall),
        .i_frame_byte(frame_byte),
        .i_last_byte (last_byte),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending),
        .o_frames    (chk_frames)
    );

    // receiver stall pattern, in randomly chosen modes
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode = t_rx_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        case (stall_mode)
            RX_FREE:  out_stall <= 1'b0;
            RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:  out_stall <= stall_left[2];
        endcase
    end

    always @(posedge clk) begin
        if ((tick_valid && !tick_stall) || (byte_valid && !out_stall) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // called right after a falling edge; returns right after a falling edge
    task automatic send_tick(input logic [STEP_W-1:0] rise, input logic [STEP_W-1:0] fall);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                tick_valid <= 1'b0;
                rise_step  <= STEP_W'($urandom_range(0, 255));
                fall_step  <= STEP_W'($urandom_range(0, 255));
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        tick_valid <= 1'b1;
        rise_step  <= rise;
        fall_step  <= fall;
        @(posedge clk);
        while (tick_stall) @(posedge clk);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        tick_valid <= 1'b0;
        burst_left = 0;
        while (chk_pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [STEP_W-1:0] fall_pick();
        if ($urandom_range(0, 3) == 0) return STEP_W'($urandom_range(0, 255));
        return STEP_W'($urandom_range(30, 99));
    endfunction

    initial begin
        int climbed;
        int climb_ticks;
        int r;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // zero frames under reset defaults
        send_tick(8'h00, 8'hFF);
        send_tick(8'hFF, 8'h00);
        settle();
        write_reg(CFG_ZERO_COUNT, 20'hFFFFF);
        write_reg(CFG_STABLE_LIMIT, 20'd255);
        write_reg(CFG_FINAL_WEIGHT, 20'hFFFFF);
        write_reg(CFG_UNUSED, 20'h00000);
        send_tick(8'h55, 8'hAA);
        send_tick(8'hAA, 8'h55);
        send_tick(8'h01, 8'h80);
        settle();

        // count already past the new target: silent tick, then rising
        write_reg(CFG_ZERO_COUNT, 20'd0);
        send_tick(8'h0F, 8'hF0);
        send_tick(8'h00, 8'h00);
        send_tick(8'hFF, 8'h7F);
        send_tick(8'h01, 8'hFE);
        climbed = 256;

        // climb well above the next target
        climb_ticks = 0;
        while (climbed < CLIMB_TARGET) begin
            r = $urandom_range(192, 255);
            send_tick(STEP_W'(r), STEP_W'($urandom_range(0, 255)));
            climbed += r;
            climb_ticks++;
        end
        settle();

        // target below the weight: next rising tick clamps and holds
        write_reg(CFG_FINAL_WEIGHT, 20'd6000);
        send_tick(STEP_W'($urandom_range(0, 255)), STEP_W'($urandom_range(0, 255)));
        repeat (STABLE_TICKS) send_tick(STEP_W'($urandom_range(0, 255)), fall_pick());
        settle();

        write_reg(CFG_STABLE_LIMIT, 20'd0);
        write_reg(CFG_FINAL_WEIGHT, 20'd0);
        repeat (TAIL_TICKS) send_tick(STEP_W'($urandom_range(0, 255)), fall_pick());
        settle();
        repeat (20) @(negedge clk);

        $display("%0d ticks sent (%0d in the climb), %0d frames checked", ticks_sent,
                 climb_ticks, chk_frames);
        $display("phases covered: zero, rising with clamp, stable, descending, done");
        if (chk_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[scale_weight_frame_sequencer.f]
+incdir+src
src/swfs_pkg.sv
src/scale_weight_frame_sequencer.sv
tb/scale_weight_frame_sequencer_chk.sv
tb/scale_weight_frame_sequencer_tb.sv
